### src/inverted_index_builder_top_defines.svh
// assertion macros for the inverted index builder
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef INVERTED_INDEX_BUILDER_TOP_DEFINES_SVH
`define INVERTED_INDEX_BUILDER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IIB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iib: same-cycle check failed");

// next-cycle implication, checked out of reset
`define IIB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iib: next-cycle check failed");

`endif

### src/iib_pkg.sv
// shared types and constants of the inverted index builder
// no dependencies; used by every module of the block but iib_ram
`default_nettype none

package iib_pkg;

  // fixed field widths of the transaction payloads
  localparam int CidW = 11;
  localparam int QidW = 16;

  // result status codes
  typedef enum logic [2:0] {
    STS_INSERTED = 3'd0,
    STS_ENTRY    = 3'd1,
    STS_FULL     = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_BUSY     = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_RED,
    S_INS_RD,
    S_INS_WR,
    S_SCAN_ADV,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FETCH_RD,
    S_FETCH_USE,
    S_RESP
  } state_e;

  // datapath operation for the current cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_REFUSE,
    OP_RD_START,
    OP_REDUCE,
    OP_INS_RD,
    OP_INS_WR,
    OP_SCAN_ADV,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_SCAN_HIT,
    OP_FETCH_RD,
    OP_FETCH_USE
  } dp_op_e;

  // function of the shared step unit
  typedef enum logic [1:0] {
    STEP_INC,
    STEP_DEC,
    STEP_SUB_N
  } step_e;

  // sequencer to datapath
  typedef struct packed {
    logic    in_ready;
    logic    capture;
    dp_op_e  op;
    status_e code;
    logic    out_load;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_cid_big;
    logic cid_big;
    logic reading;
    logic full;
    logic empty;
    logic seek_pend;
    logic used_hit;
    logic clr_done;
  } stat_t;

  // one result transaction
  typedef struct packed {
    status_e         status;
    logic [CidW-1:0] cluster;
    logic [QidW-1:0] query;
    logic            first;
    logic            last;
  } res_t;

endpackage

`default_nettype wire

### src/iib_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module iib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/iib_step.sv
// shared step unit: increment, decrement or subtract the cluster count
// depends on iib_pkg
`default_nettype none

module iib_step #(
  parameter int W            = 16,
  parameter int NUM_CLUSTERS = 2048
) (
  input  wire logic [W-1:0]        a_i,
  input  wire iib_pkg::step_e      sel_i,
  output      logic [W-1:0]        y_o
);

  localparam logic [W-1:0] NegN = W'(-NUM_CLUSTERS);

  logic [W-1:0] b;

  // addend select
  always_comb begin
    unique case (sel_i)
      iib_pkg::STEP_INC:   b = W'(1);
      iib_pkg::STEP_DEC:   b = '1;
      iib_pkg::STEP_SUB_N: b = NegN;
      default:             b = '0;
    endcase
  end

  assign y_o = a_i + b;

endmodule

`default_nettype wire

### src/iib_fsm.sv
// sequencer of the inverted index builder
// depends on iib_pkg; drives the datapath through ctrl_t
`default_nettype none

module iib_fsm (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           func_i,
  input  wire logic           out_free_i,
  input  wire iib_pkg::stat_t stat_i,
  output      iib_pkg::ctrl_t ctrl_o
);

  iib_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = in_valid_i && (state_q == iib_pkg::S_IDLE);

  // state register, clearing pass first after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iib_pkg::S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iib_pkg::S_CLR: begin
        if (stat_i.clr_done) state_d = iib_pkg::S_IDLE;
      end
      iib_pkg::S_IDLE: begin
        if (accept) begin
          priority if (func_i && !stat_i.reading) begin
            state_d = stat_i.empty ? iib_pkg::S_RESP : iib_pkg::S_SCAN_RD;
          end else if (func_i) begin
            state_d = stat_i.seek_pend ? iib_pkg::S_SCAN_ADV : iib_pkg::S_FETCH_RD;
          end else if (stat_i.reading || stat_i.full) begin
            state_d = iib_pkg::S_RESP;
          end else begin
            state_d = stat_i.in_cid_big ? iib_pkg::S_RED : iib_pkg::S_INS_RD;
          end
        end
      end
      iib_pkg::S_RED: begin
        if (!stat_i.cid_big) state_d = iib_pkg::S_INS_RD;
      end
      iib_pkg::S_INS_RD:    state_d = iib_pkg::S_INS_WR;
      iib_pkg::S_INS_WR:    state_d = iib_pkg::S_RESP;
      iib_pkg::S_SCAN_ADV:  state_d = iib_pkg::S_SCAN_RD;
      iib_pkg::S_SCAN_RD:   state_d = iib_pkg::S_SCAN_CHK;
      iib_pkg::S_SCAN_CHK: begin
        state_d = stat_i.used_hit ? iib_pkg::S_FETCH_RD : iib_pkg::S_SCAN_RD;
      end
      iib_pkg::S_FETCH_RD:  state_d = iib_pkg::S_FETCH_USE;
      iib_pkg::S_FETCH_USE: state_d = iib_pkg::S_RESP;
      iib_pkg::S_RESP: begin
        if (out_free_i) state_d = iib_pkg::S_IDLE;
      end
      default:              state_d = iib_pkg::S_CLR;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.op       = iib_pkg::OP_NONE;
    ctrl_o.code     = iib_pkg::STS_INSERTED;
    unique case (state_q)
      iib_pkg::S_CLR: ctrl_o.op = iib_pkg::OP_CLEAR;
      iib_pkg::S_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.capture  = accept;
        if (accept) begin
          priority if (func_i && !stat_i.reading) begin
            if (stat_i.empty) begin
              ctrl_o.op   = iib_pkg::OP_REFUSE;
              ctrl_o.code = iib_pkg::STS_EMPTY;
            end else begin
              ctrl_o.op   = iib_pkg::OP_RD_START;
            end
          end else if (func_i) begin
            ctrl_o.op   = iib_pkg::OP_NONE;
          end else if (stat_i.reading) begin
            ctrl_o.op   = iib_pkg::OP_REFUSE;
            ctrl_o.code = iib_pkg::STS_BUSY;
          end else if (stat_i.full) begin
            ctrl_o.op   = iib_pkg::OP_REFUSE;
            ctrl_o.code = iib_pkg::STS_FULL;
          end else begin
            ctrl_o.op   = iib_pkg::OP_NONE;
          end
        end
      end
      iib_pkg::S_RED: begin
        ctrl_o.op = stat_i.cid_big ? iib_pkg::OP_REDUCE : iib_pkg::OP_NONE;
      end
      iib_pkg::S_INS_RD:    ctrl_o.op = iib_pkg::OP_INS_RD;
      iib_pkg::S_INS_WR:    ctrl_o.op = iib_pkg::OP_INS_WR;
      iib_pkg::S_SCAN_ADV:  ctrl_o.op = iib_pkg::OP_SCAN_ADV;
      iib_pkg::S_SCAN_RD:   ctrl_o.op = iib_pkg::OP_SCAN_RD;
      iib_pkg::S_SCAN_CHK: begin
        ctrl_o.op = stat_i.used_hit ? iib_pkg::OP_SCAN_HIT : iib_pkg::OP_SCAN_NEXT;
      end
      iib_pkg::S_FETCH_RD:  ctrl_o.op = iib_pkg::OP_FETCH_RD;
      iib_pkg::S_FETCH_USE: ctrl_o.op = iib_pkg::OP_FETCH_USE;
      iib_pkg::S_RESP:      ctrl_o.out_load = out_free_i;
      default:              ctrl_o.op = iib_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

### src/iib_dp.sv
// datapath: index memories, counters, read cursor and result register
// depends on iib_pkg, iib_ram and iib_step
`default_nettype none

module iib_dp #(
  parameter int NUM_CLUSTERS = 2048,
  parameter int CAPACITY     = 32768
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire iib_pkg::ctrl_t            ctrl_i,
  input  wire logic [iib_pkg::CidW-1:0]  cluster_id_i,
  input  wire logic [iib_pkg::QidW-1:0]  query_id_i,
  output      iib_pkg::stat_t            stat_o,
  output      iib_pkg::res_t             res_o
);

  localparam int CW   = $clog2(NUM_CLUSTERS);
  localparam int PW   = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CidW = iib_pkg::CidW;
  localparam int QidW = iib_pkg::QidW;
  localparam int SW   = (CW > CntW) ? ((CW > CidW) ? CW : CidW)
                                    : ((CntW > CidW) ? CntW : CidW);

  // control registers
  logic [CW-1:0]   scan_c_q, scan_c_d;
  logic [CntW-1:0] pair_count_q, pair_count_d;
  logic [CntW-1:0] remaining_q, remaining_d;
  logic [CW-1:0]   read_cluster_q, read_cluster_d;
  logic [PW-1:0]   read_pointer_q, read_pointer_d;
  logic            reading_q, reading_d;
  logic            seek_pend_q, seek_pend_d;

  // payload registers
  logic [CidW-1:0] cid_q, cid_d;
  logic [QidW-1:0] qid_q, qid_d;
  iib_pkg::res_t   res_q, res_d;

  // memory read data
  logic [0:0]      used_rd;
  logic [PW-1:0]   head_rd, tail_rd, link_rd;
  logic [QidW-1:0] query_rd;

  // used-mark write port
  logic            used_we;
  logic [CW-1:0]   used_waddr;
  logic [0:0]      used_wdata;

  // shared step unit
  logic [SW-1:0]   step_a, step_y;
  iib_pkg::step_e  step_sel;

  logic [CW-1:0]   cid_a;
  logic [PW-1:0]   ptr;
  logic [CW-1:0]   scan_wrap;
  logic            is_last, is_tail, is_first;

  assign cid_a     = CW'(cid_q);
  assign ptr       = PW'(pair_count_q);
  assign scan_wrap = (scan_c_q == CW'(NUM_CLUSTERS - 1)) ? '0 : CW'(step_y);
  assign is_last   = (remaining_q == CntW'(1));
  assign is_tail   = (read_pointer_q == tail_rd);
  assign is_first  = (read_pointer_q == head_rd);

  // operand select for the step unit
  always_comb begin
    unique case (ctrl_i.op)
      iib_pkg::OP_REDUCE: begin
        step_a   = SW'(cid_q);
        step_sel = iib_pkg::STEP_SUB_N;
      end
      iib_pkg::OP_INS_WR: begin
        step_a   = SW'(pair_count_q);
        step_sel = iib_pkg::STEP_INC;
      end
      iib_pkg::OP_FETCH_USE: begin
        step_a   = SW'(remaining_q);
        step_sel = iib_pkg::STEP_DEC;
      end
      default: begin
        step_a   = SW'(scan_c_q);
        step_sel = iib_pkg::STEP_INC;
      end
    endcase
  end

  iib_step #(
    .W            (SW),
    .NUM_CLUSTERS (NUM_CLUSTERS)
  ) u_step (
    .a_i   (step_a),
    .sel_i (step_sel),
    .y_o   (step_y)
  );

  // used marks: cleared after reset, set on first insert, cleared as read-out leaves a cluster
  always_comb begin
    used_we    = 1'b0;
    used_waddr = scan_c_q;
    used_wdata = 1'b0;
    unique case (ctrl_i.op)
      iib_pkg::OP_CLEAR:     used_we = 1'b1;
      iib_pkg::OP_INS_WR: begin
        used_we    = !used_rd[0];
        used_waddr = cid_a;
        used_wdata = 1'b1;
      end
      iib_pkg::OP_FETCH_USE: begin
        used_we    = is_last || is_tail;
        used_waddr = read_cluster_q;
      end
      default:               used_we = 1'b0;
    endcase
  end

  iib_ram #(.WIDTH(1), .DEPTH(NUM_CLUSTERS)) u_used_mem (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i ((ctrl_i.op == iib_pkg::OP_INS_RD) ? cid_a : scan_c_q),
    .rdata_o (used_rd)
  );

  iib_ram #(.WIDTH(PW), .DEPTH(NUM_CLUSTERS)) u_head_mem (
    .clk_i   (clk_i),
    .we_i    ((ctrl_i.op == iib_pkg::OP_INS_WR) && !used_rd[0]),
    .waddr_i (cid_a),
    .wdata_i (ptr),
    .raddr_i ((ctrl_i.op == iib_pkg::OP_SCAN_RD) ? scan_c_q : read_cluster_q),
    .rdata_o (head_rd)
  );

  iib_ram #(.WIDTH(PW), .DEPTH(NUM_CLUSTERS)) u_tail_mem (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.op == iib_pkg::OP_INS_WR),
    .waddr_i (cid_a),
    .wdata_i (ptr),
    .raddr_i ((ctrl_i.op == iib_pkg::OP_INS_RD) ? cid_a : read_cluster_q),
    .rdata_o (tail_rd)
  );

  iib_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_link_mem (
    .clk_i   (clk_i),
    .we_i    ((ctrl_i.op == iib_pkg::OP_INS_WR) && used_rd[0]),
    .waddr_i (tail_rd),
    .wdata_i (ptr),
    .raddr_i (read_pointer_q),
    .rdata_o (link_rd)
  );

  iib_ram #(.WIDTH(QidW), .DEPTH(CAPACITY)) u_query_mem (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.op == iib_pkg::OP_INS_RD),
    .waddr_i (ptr),
    .wdata_i (qid_q),
    .raddr_i (read_pointer_q),
    .rdata_o (query_rd)
  );

  // next values of counters, cursor and result
  always_comb begin
    scan_c_d       = scan_c_q;
    pair_count_d   = pair_count_q;
    remaining_d    = remaining_q;
    read_cluster_d = read_cluster_q;
    read_pointer_d = read_pointer_q;
    reading_d      = reading_q;
    seek_pend_d    = seek_pend_q;
    cid_d          = ctrl_i.capture ? cluster_id_i : cid_q;
    qid_d          = ctrl_i.capture ? query_id_i : qid_q;
    res_d          = res_q;
    unique case (ctrl_i.op)
      iib_pkg::OP_CLEAR:     scan_c_d = scan_wrap;
      iib_pkg::OP_REFUSE: begin
        res_d        = '0;
        res_d.status = ctrl_i.code;
      end
      iib_pkg::OP_RD_START: begin
        reading_d   = 1'b1;
        remaining_d = pair_count_q;
        scan_c_d    = '0;
        seek_pend_d = 1'b0;
      end
      iib_pkg::OP_REDUCE:    cid_d = CidW'(step_y);
      iib_pkg::OP_INS_WR: begin
        pair_count_d = CntW'(step_y);
        res_d        = '0;
        res_d.status = iib_pkg::STS_INSERTED;
      end
      iib_pkg::OP_SCAN_ADV: begin
        scan_c_d    = scan_wrap;
        seek_pend_d = 1'b0;
      end
      iib_pkg::OP_SCAN_NEXT: scan_c_d = scan_wrap;
      iib_pkg::OP_SCAN_HIT: begin
        read_cluster_d = scan_c_q;
        read_pointer_d = head_rd;
      end
      iib_pkg::OP_FETCH_USE: begin
        remaining_d   = CntW'(step_y);
        res_d.status  = iib_pkg::STS_ENTRY;
        res_d.cluster = CidW'(read_cluster_q);
        res_d.query   = query_rd;
        res_d.first   = is_first;
        res_d.last    = is_last;
        priority if (is_last) begin
          pair_count_d   = '0;
          reading_d      = 1'b0;
          read_cluster_d = '0;
          read_pointer_d = '0;
          seek_pend_d    = 1'b0;
        end else if (is_tail) begin
          seek_pend_d    = 1'b1;
          scan_c_d       = read_cluster_q;
        end else begin
          read_pointer_d = link_rd;
        end
      end
      default:               scan_c_d = scan_c_q;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_c_q       <= '0;
      pair_count_q   <= '0;
      remaining_q    <= '0;
      read_cluster_q <= '0;
      read_pointer_q <= '0;
      reading_q      <= 1'b0;
      seek_pend_q    <= 1'b0;
    end else begin
      scan_c_q       <= scan_c_d;
      pair_count_q   <= pair_count_d;
      remaining_q    <= remaining_d;
      read_cluster_q <= read_cluster_d;
      read_pointer_q <= read_pointer_d;
      reading_q      <= reading_d;
      seek_pend_q    <= seek_pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cid_q <= cid_d;
    qid_q <= qid_d;
    res_q <= res_d;
  end

  // status toward the sequencer
  always_comb begin
    stat_o.in_cid_big = (32'(cluster_id_i) >= NUM_CLUSTERS);
    stat_o.cid_big    = (32'(cid_q) >= NUM_CLUSTERS);
    stat_o.reading    = reading_q;
    stat_o.full       = (pair_count_q == CntW'(CAPACITY));
    stat_o.empty      = (pair_count_q == '0);
    stat_o.seek_pend  = seek_pend_q;
    stat_o.used_hit   = used_rd[0];
    stat_o.clr_done   = (scan_c_q == CW'(NUM_CLUSTERS - 1));
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### src/inverted_index_builder_top.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_ready_o  | func_i, cluster_id_i, query_id_i
// out     | output    | out_valid_o / out_ready_i | status_o, cluster_id_res_o,
//         |           |                        | query_id_res_o, first_of_cluster_o,
//         |           |                        | last_of_index_o
//
// one transaction at a time; the memory ports of the index set the pace:
// an insert reads used mark and tail, then writes; a refusal goes straight to the result;
// a read-out reads then uses an entry, scanning cluster ids in turn on a change;
// below 2048 clusters an out-of-range id is reduced by NUM_CLUSTERS until in range
// after reset a clearing pass over all NUM_CLUSTERS used marks runs before in_ready_o rises
// a result waits in the output register while the next transaction is taken
//
// top level; depends on iib_pkg, iib_fsm, iib_dp and the defines header
`default_nettype none

`include "inverted_index_builder_top_defines.svh"

module inverted_index_builder_top #(
  parameter int NUM_CLUSTERS = 2048,
  parameter int CAPACITY     = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire logic                     func_i,
  input  wire logic [iib_pkg::CidW-1:0] cluster_id_i,
  input  wire logic [iib_pkg::QidW-1:0] query_id_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic [2:0]               status_o,
  output      logic [iib_pkg::CidW-1:0] cluster_id_res_o,
  output      logic [iib_pkg::QidW-1:0] query_id_res_o,
  output      logic                     first_of_cluster_o,
  output      logic                     last_of_index_o
);

  iib_pkg::ctrl_t ctrl;
  iib_pkg::stat_t stat;
  iib_pkg::res_t  res;
  iib_pkg::res_t  out_q;
  logic           out_valid_q, out_valid_d;
  logic           out_free;
  logic           out_fields_zero;

  assign out_free = !out_valid_q || out_ready_i;

  iib_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  iib_dp #(
    .NUM_CLUSTERS (NUM_CLUSTERS),
    .CAPACITY     (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cluster_id_i (cluster_id_i),
    .query_id_i   (query_id_i),
    .stat_o       (stat),
    .res_o        (res)
  );

  // output register valid
  always_comb begin
    priority if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_q <= res;
    end
  end

  assign in_ready_o         = ctrl.in_ready;
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_q.status;
  assign cluster_id_res_o   = out_q.cluster;
  assign query_id_res_o     = out_q.query;
  assign first_of_cluster_o = out_q.first;
  assign last_of_index_o    = out_q.last;

  // entry fields all zero
  assign out_fields_zero = !first_of_cluster_o && !last_of_index_o &&
                           (cluster_id_res_o == '0) && (query_id_res_o == '0);

  // result only overwrites the output register once it is free
  `IIB_ASSERT_IMP(a_out_load_free, ctrl.out_load, !out_valid_q || out_ready_i)
  // a taken transaction keeps the sequencer busy in the next cycle
  `IIB_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // entry fields stay zero on every non-delivery status
  `IIB_ASSERT_IMP(a_zero_fields, out_valid_o && (status_o != iib_pkg::STS_ENTRY), out_fields_zero)

endmodule

`default_nettype wire

### test/tb_top.sv
// testbench for inverted_index_builder_top: insert and read-out transactions
// are checked against an index predictor kept in this file; depends on iib_pkg
`timescale 1ns / 100ps

module tb_top;

  localparam int NCL         = 2048;
  localparam int CAP         = 32768;
  localparam int HOLD_LEN    = 400;
  localparam int STALL_LIMIT = 25000;
  localparam int CidW        = iib_pkg::CidW;
  localparam int QidW        = iib_pkg::QidW;

  // function codes of an input transaction
  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_READ   = 1'b1;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            in_valid_i   = 1'b0;
  logic            func_i       = FN_INSERT;
  logic [CidW-1:0] cluster_id_i = '0;
  logic [QidW-1:0] query_id_i   = '0;
  logic            out_ready_i  = 1'b0;
  logic            in_ready_o;
  logic            out_valid_o;
  logic [2:0]      status_o;
  logic [CidW-1:0] cluster_id_res_o;
  logic [QidW-1:0] query_id_res_o;
  logic            first_of_cluster_o;
  logic            last_of_index_o;

  // shared among the stimulus, the result sink and the result check
  int  stall_pct  = 10;
  bit  hold_req   = 1'b0;
  int  sent_items = 0;
  int  mismatches = 0;

  // index predictor state
  logic [NCL-1:0]  used_mark = '0;
  logic [14:0]     chain_head [NCL];
  logic [14:0]     chain_tail [NCL];
  logic [14:0]     chain_next [CAP];
  logic [QidW-1:0] query_store [CAP];
  int unsigned     fill_count   = 0;
  int unsigned     scan_cluster = 0;
  int unsigned     left_to_read = 0;
  logic [14:0]     cursor       = '0;
  bit              draining     = 1'b0;

  iib_pkg::res_t index_answers_q [$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  inverted_index_builder_top #(
    .NUM_CLUSTERS(NCL),
    .CAPACITY    (CAP)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .cluster_id_i      (cluster_id_i),
    .query_id_i        (query_id_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .cluster_id_res_o  (cluster_id_res_o),
    .query_id_res_o    (query_id_res_o),
    .first_of_cluster_o(first_of_cluster_o),
    .last_of_index_o   (last_of_index_o)
  );

  // point the read-out at the first used cluster at or above start, else at cluster zero
  function automatic void seek_used(input int unsigned start);
    int unsigned c;
    c = start;
    while (c < NCL && !used_mark[c]) c++;
    if (c >= NCL) c = 0;
    scan_cluster = c;
    cursor       = chain_head[c];
  endfunction

  // expected result of one accepted transaction, updating the index
  function automatic iib_pkg::res_t next_index_result(input logic f,
                                                      input logic [CidW-1:0] c,
                                                      input logic [QidW-1:0] q);
    iib_pkg::res_t r;
    logic [14:0]   ptr;
    r        = '0;
    r.status = iib_pkg::STS_INSERTED;
    if (f == FN_INSERT) begin
      if (draining) begin
        r.status = iib_pkg::STS_BUSY;
      end else if (fill_count >= CAP) begin
        r.status = iib_pkg::STS_FULL;
      end else begin
        ptr              = fill_count[14:0];
        query_store[ptr] = q;
        if (!used_mark[c]) begin
          used_mark[c]  = 1'b1;
          chain_head[c] = ptr;
        end else begin
          chain_next[chain_tail[c]] = ptr;
        end
        chain_tail[c] = ptr;
        fill_count++;
      end
    end else if (!draining && fill_count == 0) begin
      r.status = iib_pkg::STS_EMPTY;
    end else begin
      if (!draining) begin
        draining     = 1'b1;
        left_to_read = fill_count;
        seek_used(0);
      end
      ptr       = cursor;
      r.status  = iib_pkg::STS_ENTRY;
      r.cluster = scan_cluster[CidW-1:0];
      r.query   = query_store[ptr];
      r.first   = (ptr == chain_head[scan_cluster]);
      left_to_read--;
      r.last    = (left_to_read == 0);
      if (r.last) begin
        // whole index delivered: back to accepting inserts
        used_mark    = '0;
        fill_count   = 0;
        draining     = 1'b0;
        scan_cluster = 0;
        cursor       = '0;
      end else if (ptr == chain_tail[scan_cluster]) begin
        seek_used(scan_cluster + 1);
      end else begin
        cursor = chain_next[ptr];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // offer one transaction, wait for it to be taken, record its expected result
  task automatic send_item(input logic f, input logic [CidW-1:0] c,
                           input logic [QidW-1:0] q);
    if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    cluster_id_i <= c;
    query_id_i   <= q;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    index_answers_q = {index_answers_q, next_index_result(f, c, q)};
    sent_items++;
  endtask

  // sender pauses until every outstanding result has come back
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (index_answers_q.size() != 0);
  endtask

  // one fill of the index followed by its complete read-out, with some noise
  task automatic run_fill(input int n_ins);
    int              mode;
    int              k;
    logic [CidW-1:0] c;
    logic [QidW-1:0] q;
    logic [CidW-1:0] hot [4];
    mode = $urandom_range(0, 3);
    foreach (hot[i]) hot[i] = CidW'($urandom);
    for (k = 0; k < n_ins; k++) begin
      // an early read starts read-out and turns later inserts into busy refusals
      if ($urandom_range(0, 59) == 0) send_item(FN_READ, CidW'($urandom), QidW'($urandom));
      case (mode)
        0:       c = CidW'($urandom);
        1:       c = hot[$urandom_range(0, 3)];
        2:       c = $urandom_range(0, 1) ? '1 : '0;
        default: c = CidW'($urandom_range(NCL - 8, NCL - 1));
      endcase
      if ($urandom_range(0, 15) == 0) q = $urandom_range(0, 1) ? '1 : '0;
      else q = QidW'($urandom);
      send_item(FN_INSERT, c, q);
    end
    while (draining || fill_count != 0) begin
      if ($urandom_range(0, 9) == 0) send_item(FN_INSERT, CidW'($urandom), QidW'($urandom));
      send_item(FN_READ, CidW'($urandom), QidW'($urandom));
    end
    if ($urandom_range(0, 3) == 0) send_item(FN_READ, CidW'($urandom), QidW'($urandom));
  endtask

  // field extremes, duplicates, refusals and the last-entry wrap
  task automatic test_directed_cases();
    int k;
    stall_pct = 10;
    send_item(FN_READ, '0, '0);
    send_item(FN_INSERT, '0, '0);
    send_item(FN_INSERT, '1, '1);
    send_item(FN_INSERT, '0, '1);
    send_item(FN_INSERT, '1, '1);
    send_item(FN_INSERT, 11'd1024, 16'h5555);
    send_item(FN_INSERT, 11'd1023, 16'hAAAA);
    send_item(FN_INSERT, '0, 16'd1);
    send_item(FN_READ, '1, '1);
    send_item(FN_INSERT, 11'd5, 16'd5);
    for (k = 0; k < 6; k++) send_item(FN_READ, '0, '0);
    send_item(FN_READ, '0, '0);
    // only the top cluster used: longest scan from cluster zero
    send_item(FN_INSERT, '1, 16'h1234);
    send_item(FN_READ, '0, '0);
    send_item(FN_INSERT, 11'd7, 16'd7);
    send_item(FN_READ, '0, '0);
  endtask

  // receiver holds off while inserts keep coming, then the sender pauses
  task automatic test_backpressure();
    int k;
    wait_all_results();
    stall_pct = 0;
    hold_req  = 1'b1;
    for (k = 0; k < 30; k++) send_item(FN_INSERT, CidW'($urandom), QidW'($urandom));
    wait_all_results();
    run_fill(0);
  endtask

  // mostly small fills with random content and varying idle pressure
  task automatic test_random_fills();
    int stop_at;
    int pick;
    stop_at = sent_items + 1400;
    while (sent_items < stop_at) begin
      pick      = $urandom_range(0, 2);
      stall_pct = (pick == 0) ? 0 : (pick == 1) ? 4 : 15;
      run_fill(($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24));
    end
  endtask

  // last stretch with no idling on either side
  task automatic test_calm_finish();
    int stop_at;
    stall_pct = 0;
    stop_at   = sent_items + 350;
    while (sent_items < stop_at) run_fill($urandom_range(1, 30));
  endtask

  // result side: random stalls, and one long hold-off on request
  initial begin : result_sink
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    iib_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (index_answers_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, status %0d", status_o));
      end else begin
        want = index_answers_q.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
        if (cluster_id_res_o !== want.cluster)
          report_mismatch($sformatf("cluster %0d, want %0d", cluster_id_res_o, want.cluster));
        if (query_id_res_o !== want.query)
          report_mismatch($sformatf("query %0d, want %0d", query_id_res_o, want.query));
        if (first_of_cluster_o !== want.first)
          report_mismatch($sformatf("first %b, want %b", first_of_cluster_o, want.first));
        if (last_of_index_o !== want.last)
          report_mismatch($sformatf("last %b, want %b", last_of_index_o, want.last));
      end
    end
  end

  // ends the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_backpressure();
    test_random_fills();
    test_calm_finish();
    wait_all_results();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && index_answers_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
